FILE: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants for the sphere frustum cull test
// Field widths, verdict codes, configuration register indexes, the
// configuration bundle and the pipeline advance controls.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // Field widths
    localparam int unsigned COORD_W   = 32;                  // Q16.16 signed coordinate
    localparam int unsigned DIST_W    = 31;                  // Q15.16 unsigned distance/radius
    localparam int unsigned NORM_W    = 16;                  // Q1.14 signed normal component
    localparam int unsigned CFG_W     = 32;                  // widest configuration register
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned VERDICT_W = 2;
    localparam int unsigned RS_SHIFT  = 14;                  // radius to product scale

    // Derived arithmetic widths
    localparam int unsigned PROD_W  = COORD_W + NORM_W;      // coordinate times normal
    localparam int unsigned SUM_W   = PROD_W + 1;            // sum of two products
    localparam int unsigned CMP_W   = SUM_W + 1;             // compare width vs. scaled radius
    localparam int unsigned DEPTH_W = COORD_W + 1;           // z plus or minus radius
    localparam int unsigned DCMP_W  = DEPTH_W + 1;           // compare width vs. clip distance

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_CROSSES = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INSIDE  = 2'd2;

    // Reset value of the near distance: 1.0 in Q15.16
    localparam logic [DIST_W-1:0] NEAR_RESET = 31'd65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR  = 3'd0,
        CFG_FAR   = 3'd1,
        CFG_LEFT  = 3'd2,
        CFG_RIGHT = 3'd3,
        CFG_UP    = 3'd4,
        CFG_DOWN  = 3'd5
    } cfg_index_t;

    // Configuration register bundle
    typedef struct packed {
        logic [DIST_W-1:0] near_distance;
        logic [DIST_W-1:0] far_distance;
        logic [CFG_W-1:0]  left_plane;
        logic [CFG_W-1:0]  right_plane;
        logic [CFG_W-1:0]  up_plane;
        logic [CFG_W-1:0]  down_plane;
    } sfc_cfg_t;

    // Stage load enables handed to the datapath lanes
    typedef struct packed {
        logic s2_en;
        logic s3_en;
    } sfc_ctl_t;

endpackage

FILE: rtl/sfc_cfg.sv
// ----------------------------------------------------------------------------
// sfc_cfg: configuration register file
// Holds the clip distances and the four side plane normals, written through
// a plain indexed write port.
// ----------------------------------------------------------------------------
module sfc_cfg
    import sfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output sfc_cfg_t             cfg
);

    sfc_cfg_t cfg_reg;
    sfc_cfg_t cfg_next;

    // Decode the write; drop writes to unused indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NEAR:  cfg_next.near_distance = cfg_data[DIST_W-1:0];
                CFG_FAR:   cfg_next.far_distance  = cfg_data[DIST_W-1:0];
                CFG_LEFT:  cfg_next.left_plane    = cfg_data;
                CFG_RIGHT: cfg_next.right_plane   = cfg_data;
                CFG_UP:    cfg_next.up_plane      = cfg_data;
                CFG_DOWN:  cfg_next.down_plane    = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_distance <= NEAR_RESET;
            cfg_reg.far_distance  <= '0;
            cfg_reg.left_plane    <= '0;
            cfg_reg.right_plane   <= '0;
            cfg_reg.up_plane      <= '0;
            cfg_reg.down_plane    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/sfc_depth.sv
// ----------------------------------------------------------------------------
// sfc_depth: near and far plane test
// Stage 2 forms z - r and z + r; stage 3 compares both against the clip
// distances and registers the outside and straddle flags.
// ----------------------------------------------------------------------------
module sfc_depth
    import sfc_pkg::*;
(
    input  logic                      clk,
    input  sfc_ctl_t                  ctl,
    input  logic [DIST_W-1:0]         near_distance,
    input  logic [DIST_W-1:0]         far_distance,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic [DIST_W-1:0]         radius,
    output logic                      out_flag,
    output logic                      cross_flag
);

    localparam int unsigned RPAD_W = DEPTH_W - DIST_W;
    localparam int unsigned DPAD_W = DCMP_W - DIST_W;

    logic signed [DEPTH_W-1:0] zlo_next;
    logic signed [DEPTH_W-1:0] zhi_next;
    logic signed [DEPTH_W-1:0] zlo_reg;
    logic signed [DEPTH_W-1:0] zhi_reg;
    logic signed [DCMP_W-1:0]  zlo_x;
    logic signed [DCMP_W-1:0]  zhi_x;
    logic signed [DCMP_W-1:0]  neg_near;
    logic signed [DCMP_W-1:0]  neg_far;
    logic                      far_on;
    logic                      out_next;
    logic                      cross_next;
    logic                      out_flag_reg;
    logic                      cross_flag_reg;

    // Near and far extent of the sphere along z
    assign zlo_next = $signed({pos_z[COORD_W-1], pos_z}) - $signed({{RPAD_W{1'b0}}, radius});
    assign zhi_next = $signed({pos_z[COORD_W-1], pos_z}) + $signed({{RPAD_W{1'b0}}, radius});

    always_ff @(posedge clk)
    begin
        if (ctl.s2_en)
        begin
            zlo_reg <= zlo_next;
            zhi_reg <= zhi_next;
        end
    end

    // Compare against the clip planes at z = -near and z = -far
    assign zlo_x    = {zlo_reg[DEPTH_W-1], zlo_reg};
    assign zhi_x    = {zhi_reg[DEPTH_W-1], zhi_reg};
    assign neg_near = -$signed({{DPAD_W{1'b0}}, near_distance});
    assign neg_far  = -$signed({{DPAD_W{1'b0}}, far_distance});
    assign far_on   = (far_distance != '0);

    assign out_next   = (zlo_x > neg_near) || (far_on && (zhi_x < neg_far));
    assign cross_next = (zhi_x > neg_near) || (far_on && (zlo_x < neg_far));

    always_ff @(posedge clk)
    begin
        if (ctl.s3_en)
        begin
            out_flag_reg   <= out_next;
            cross_flag_reg <= cross_next;
        end
    end

    assign out_flag   = out_flag_reg;
    assign cross_flag = cross_flag_reg;

endmodule

FILE: rtl/sfc_side.sv
// ----------------------------------------------------------------------------
// sfc_side: one side plane lane
// Stage 2 registers the two normal products, stage 3 registers their sum,
// and the flags compare that sum against the radius at product scale.
// ----------------------------------------------------------------------------
module sfc_side
    import sfc_pkg::*;
(
    input  logic                      clk,
    input  sfc_ctl_t                  ctl,
    input  logic [CFG_W-1:0]          plane,
    input  logic signed [COORD_W-1:0] coord,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic [DIST_W-1:0]         radius,
    output logic                      out_flag,
    output logic                      cross_flag
);

    localparam int unsigned PAD_W = CMP_W - DIST_W - RS_SHIFT;

    logic signed [NORM_W-1:0] n_coord;
    logic signed [NORM_W-1:0] n_z;
    logic signed [PROD_W-1:0] p_coord_reg;
    logic signed [PROD_W-1:0] p_z_reg;
    logic [DIST_W-1:0]        r2_reg;
    logic signed [SUM_W-1:0]  d_reg;
    logic [DIST_W-1:0]        r3_reg;
    logic signed [CMP_W-1:0]  d_x;
    logic signed [CMP_W-1:0]  rs_pos;
    logic signed [CMP_W-1:0]  rs_neg;

    // Split the packed normal
    assign n_coord = plane[NORM_W-1:0];
    assign n_z     = plane[CFG_W-1:NORM_W];

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (ctl.s2_en)
        begin
            p_coord_reg <= coord * n_coord;
            p_z_reg     <= pos_z * n_z;
            r2_reg      <= radius;
        end
    end

    // Sum stage
    always_ff @(posedge clk)
    begin
        if (ctl.s3_en)
        begin
            d_reg  <= {p_coord_reg[PROD_W-1], p_coord_reg} + {p_z_reg[PROD_W-1], p_z_reg};
            r3_reg <= r2_reg;
        end
    end

    // Classify the signed distance against plus and minus the scaled radius
    assign d_x    = {d_reg[SUM_W-1], d_reg};
    assign rs_pos = {{PAD_W{1'b0}}, r3_reg, {RS_SHIFT{1'b0}}};
    assign rs_neg = -rs_pos;

    assign out_flag   = (d_x < rs_neg);
    assign cross_flag = (d_x < rs_pos);

endmodule

FILE: rtl/sphere_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// sphere_frustum_cull_test: sphere versus view frustum classifier
// Classifies a view-space sphere as outside, straddling or fully inside the
// frustum bounded by the near, optional far and four side planes.
// ----------------------------------------------------------------------------
// The block takes one sphere per clock cycle while its output is not stalled
// and returns one verdict per sphere in arrival order. An accepted sphere
// passes through an input register loaded at the accepting edge, a multiply
// stage for the side plane normals, a sum stage, and the output register
// where the side plane compares and the verdict merge land.
// The 32x16 normal products set the pipeline depth. Every stage advances
// independently, so bubbles close up and a stalled output holds the pipeline
// without losing or repeating a transaction. Configuration writes take effect
// on the next cycle and must be made while no sphere is in flight.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_test
    import sfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic [DIST_W-1:0]         radius,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [VERDICT_W-1:0]      verdict
);

    localparam int unsigned LANES = 4;

    sfc_cfg_t                  cfg;
    sfc_ctl_t                  ctl;
    logic                      s1_en;
    logic                      s2_en;
    logic                      s3_en;
    logic                      out_en;
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s3_valid_reg;
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] z_reg;
    logic [DIST_W-1:0]         r_reg;
    logic [VERDICT_W-1:0]      verdict_reg;
    logic [VERDICT_W-1:0]      verdict_next;
    logic                      depth_out;
    logic                      depth_cross;
    logic [LANES-1:0]          side_out;
    logic [LANES-1:0]          side_cross;

    // Configuration registers
    sfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance a stage when it is empty or its contents move on
    assign out_en   = !out_valid_reg || out_ready;
    assign s3_en    = !s3_valid_reg || out_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    assign ctl.s2_en = s2_en;
    assign ctl.s3_en = s3_en;

    // Carry valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (out_en)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Capture the incoming sphere
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            z_reg <= pos_z;
            r_reg <= radius;
        end
    end

    // Near and far planes
    sfc_depth u_depth (
        .clk           (clk),
        .ctl           (ctl),
        .near_distance (cfg.near_distance),
        .far_distance  (cfg.far_distance),
        .pos_z         (z_reg),
        .radius        (r_reg),
        .out_flag      (depth_out),
        .cross_flag    (depth_cross)
    );

    // Side planes: left, right use x; up, down use y
    sfc_side u_left (
        .clk        (clk),
        .ctl        (ctl),
        .plane      (cfg.left_plane),
        .coord      (x_reg),
        .pos_z      (z_reg),
        .radius     (r_reg),
        .out_flag   (side_out[0]),
        .cross_flag (side_cross[0])
    );

    sfc_side u_right (
        .clk        (clk),
        .ctl        (ctl),
        .plane      (cfg.right_plane),
        .coord      (x_reg),
        .pos_z      (z_reg),
        .radius     (r_reg),
        .out_flag   (side_out[1]),
        .cross_flag (side_cross[1])
    );

    sfc_side u_up (
        .clk        (clk),
        .ctl        (ctl),
        .plane      (cfg.up_plane),
        .coord      (y_reg),
        .pos_z      (z_reg),
        .radius     (r_reg),
        .out_flag   (side_out[2]),
        .cross_flag (side_cross[2])
    );

    sfc_side u_down (
        .clk        (clk),
        .ctl        (ctl),
        .plane      (cfg.down_plane),
        .coord      (y_reg),
        .pos_z      (z_reg),
        .radius     (r_reg),
        .out_flag   (side_out[3]),
        .cross_flag (side_cross[3])
    );

    // Merge plane results: any outside wins, then any straddle
    always_comb
    begin
        if (depth_out || (|side_out))
            verdict_next = VERDICT_OUTSIDE;
        else if (depth_cross || (|side_cross))
            verdict_next = VERDICT_CROSSES;
        else
            verdict_next = VERDICT_INSIDE;
    end

    // Hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (out_en)
            verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

FILE: rtl/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker: port-level checks for the sphere frustum cull test
// Watches the top level's ports and flags stalls that drop results,
// back-pressure without cause and verdict codes that cannot occur.
// ----------------------------------------------------------------------------
module sfc_checker
    import sfc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [VERDICT_W-1:0]      verdict
);

    // Hold a stalled result and its verdict
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(verdict))
    ) else $error("stalled result changed or dropped");

    // Refuse input only when the output is full and stalled
    a_ready_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready)
    ) else $error("input refused without output back-pressure");

    // Drive only defined verdict codes
    a_verdict_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_OUTSIDE || verdict == VERDICT_CROSSES ||
                       verdict == VERDICT_INSIDE)
    ) else $error("undefined verdict code");

endmodule

bind sphere_frustum_cull_test sfc_checker u_sfc_checker (.*);

FILE: bench/tb_sphere_frustum_cull_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sphere_frustum_cull_test: self-checking bench for the frustum classifier
// Drives bounding spheres through the valid/ready input, predicts each verdict
// with an exact 64-bit plane evaluator, and compares every output transaction
// in order. Runs several frustum settings and handshake idling mixes.
// ----------------------------------------------------------------------------
import sfc_pkg::*;

// Track the frustum registers and the verdicts still owed by the block
class cull_board;
    logic [DIST_W-1:0]    near_dist;
    logic [DIST_W-1:0]    far_dist;
    logic [CFG_W-1:0]     side_plane [4];   // left, right, up, down
    logic [VERDICT_W-1:0] owed_verdicts [$];
    int                   fail_count;

    function new();
        near_dist     = NEAR_RESET;
        far_dist      = '0;
        side_plane[0] = '0;
        side_plane[1] = '0;
        side_plane[2] = '0;
        side_plane[3] = '0;
        fail_count    = 0;
    endfunction

    // Exact plane tests: near, optional far, then the four side planes
    function logic [VERDICT_W-1:0] classify(logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic signed [COORD_W-1:0] z,
                                            logic [DIST_W-1:0] r);
        longint               zl;
        longint               rl;
        longint               nl;
        longint               fl;
        longint               rs;
        longint               c;
        longint               d;
        logic signed [NORM_W-1:0] n_c;
        logic signed [NORM_W-1:0] n_z;
        logic [VERDICT_W-1:0] result;
        int                   i;
        zl = longint'(z);
        rl = longint'(r);
        nl = longint'(near_dist);
        fl = longint'(far_dist);
        rs = rl << RS_SHIFT;
        result = VERDICT_INSIDE;
        if (zl - rl > -nl)
            return VERDICT_OUTSIDE;
        if (zl + rl > -nl)
            result = VERDICT_CROSSES;
        // A far distance of zero switches the far plane off
        if (fl != 0)
        begin
            if (zl + rl < -fl)
                return VERDICT_OUTSIDE;
            if (zl - rl < -fl)
                result = VERDICT_CROSSES;
        end
        for (i = 0; i < 4; i++)
        begin
            c   = (i < 2) ? longint'(x) : longint'(y);
            n_c = side_plane[i][NORM_W-1:0];
            n_z = side_plane[i][CFG_W-1:NORM_W];
            d   = c * longint'(n_c) + zl * longint'(n_z);
            if (d < -rs)
                return VERDICT_OUTSIDE;
            if (d < rs)
                result = VERDICT_CROSSES;
        end
        return result;
    endfunction

    function void note_sphere(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, logic [DIST_W-1:0] r);
        owed_verdicts.push_back(classify(x, y, z, r));
    endfunction

    function void check_verdict(logic [VERDICT_W-1:0] actual);
        logic [VERDICT_W-1:0] expected;
        if (owed_verdicts.size() == 0)
        begin
            $error("verdict: unexpected transaction, expected none, actual %0d", actual);
            fail_count++;
        end
        else
        begin
            expected = owed_verdicts.pop_front();
            if (actual !== expected)
            begin
                $error("verdict mismatch: expected %0d, actual %0d", expected, actual);
                fail_count++;
            end
        end
    endfunction

    function int pending();
        return owed_verdicts.size();
    endfunction
endclass

module tb_sphere_frustum_cull_test;

    // Register indexes past the end of the map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Q1.14 value of 0.7071 and its negation, for a 90 degree frustum
    localparam logic [NORM_W-1:0] NORM_DIAG_POS = 16'h2D41;
    localparam logic [NORM_W-1:0] NORM_DIAG_NEG = 16'hD2BF;

    // Q16.16 constants used by the directed spheres
    localparam int Q_ONE      = 65536;
    localparam int Q_TEN      = 655360;
    localparam int Q_HUNDRED  = 6553600;
    localparam int Q_150      = 9830400;
    localparam int Q_200      = 13107200;
    localparam int Q_THOUSAND = 65536000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_NEAR;
    logic [CFG_W-1:0]          cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] pos_x     = '0;
    logic signed [COORD_W-1:0] pos_y     = '0;
    logic signed [COORD_W-1:0] pos_z     = '0;
    logic [DIST_W-1:0]         radius    = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [VERDICT_W-1:0]      verdict;

    int gap_pct   = 0;      // sender idle chance per cycle, percent
    int stall_pct = 0;      // receiver stall chance per cycle, percent

    cull_board board = new();

    sphere_frustum_cull_test uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .radius    (radius),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    // Randomly stall the result channel
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Record every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_sphere(pos_x, pos_y, pos_z, radius);
    end

    // Check every accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_verdict(verdict);
    end

    // Offer one sphere after a random gap and hold it until accepted
    task automatic send_sphere(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [DIST_W-1:0] r);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        pos_z    <= z;
        radius   <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    // Mostly spheres in front of the eye, some raw noise, some extreme values
    task automatic send_random_sphere();
        int          roll;
        int          depth;
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
        logic [31:0] wr;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            depth = $urandom_range(0, 1 << 28);
            wz = -depth + $urandom_range(0, 1 << 16);
            wx = $urandom_range(0, 2 * depth) - depth;
            wy = $urandom_range(0, 2 * depth) - depth;
            wr = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(0, (depth >> 3) + 1);
        end
        else if (roll < 85)
        begin
            wx = $urandom;
            wy = $urandom;
            wz = $urandom;
            wr = $urandom;
        end
        else
        begin
            wx = edge_word();
            wy = edge_word();
            wz = edge_word();
            wr = edge_word();
        end
        send_sphere(wx, wy, wz, wr[DIST_W-1:0]);
    endtask

    task automatic run_phase(input int count, input int send_gap, input int sink_stall);
        gap_pct   = send_gap;
        stall_pct = sink_stall;
        repeat (count) send_random_sphere();
    endtask

    // Stop sending, wait for every owed verdict, then let the pipe empty
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram all frustum registers while the block is idle
    task automatic program_frustum(input logic [DIST_W-1:0] near_d,
                                   input logic [DIST_W-1:0] far_d,
                                   input logic [CFG_W-1:0] left_p,
                                   input logic [CFG_W-1:0] right_p,
                                   input logic [CFG_W-1:0] up_p,
                                   input logic [CFG_W-1:0] down_p);
        logic [31:0] junk;
        drain_pipeline();
        junk = $urandom;
        write_reg(CFG_NEAR, {junk[31], near_d});
        write_reg(CFG_FAR, {junk[30], far_d});
        write_reg(CFG_LEFT, left_p);
        write_reg(CFG_RIGHT, right_p);
        write_reg(CFG_UP, up_p);
        write_reg(CFG_DOWN, down_p);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
        board.near_dist     = near_d;
        board.far_dist      = far_d;
        board.side_plane[0] = left_p;
        board.side_plane[1] = right_p;
        board.side_plane[2] = up_p;
        board.side_plane[3] = down_p;
        @(posedge clk);
    endtask

    // Random symmetric-ish frustum with inward normals
    task automatic program_random_frustum(input bit far_on);
        logic [NORM_W-1:0]  nx;
        logic [NORM_W-1:0]  ny;
        logic [NORM_W-1:0]  nz_h;
        logic [NORM_W-1:0]  nz_v;
        logic [DIST_W-1:0]  near_d;
        logic [DIST_W-1:0]  far_d;
        nx     = NORM_W'($urandom_range(2000, 16000));
        ny     = NORM_W'($urandom_range(2000, 16000));
        nz_h   = -NORM_W'($urandom_range(2000, 16000));
        nz_v   = -NORM_W'($urandom_range(2000, 16000));
        near_d = DIST_W'($urandom_range(0, 1 << 20));
        far_d  = far_on ? DIST_W'(near_d + $urandom_range(0, 1 << 28)) : '0;
        program_frustum(near_d, far_d, {nz_h, nx}, {nz_h, -nx}, {nz_v, -ny}, {nz_v, ny});
    endtask

    initial
    begin
        logic [31:0] raw [6];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: near at 1.0, far off, all side normals zero
        send_sphere(32'd0, 32'd0, 32'd0, 31'd0);
        send_sphere(32'd0, 32'd0, -Q_ONE, 31'd0);
        send_sphere(32'd0, 32'd0, -Q_ONE, 31'd1);
        send_sphere(32'd0, 32'd0, -Q_ONE - 5, 31'd5);
        send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        run_phase(100, 0, 0);

        // 90 degree frustum, near 0.1, far 1000.0
        program_frustum(31'd6554, DIST_W'(Q_THOUSAND),
                        {NORM_DIAG_NEG, NORM_DIAG_POS}, {NORM_DIAG_NEG, NORM_DIAG_NEG},
                        {NORM_DIAG_NEG, NORM_DIAG_NEG}, {NORM_DIAG_NEG, NORM_DIAG_POS});
        send_sphere(32'd0, 32'd0, -Q_HUNDRED, DIST_W'(Q_ONE));
        send_sphere(32'd0, 32'd0, -Q_HUNDRED, 31'd0);
        send_sphere(-Q_200, 32'd0, -Q_HUNDRED, DIST_W'(Q_ONE));
        send_sphere(Q_HUNDRED, 32'd0, -Q_HUNDRED, DIST_W'(Q_ONE));
        send_sphere(32'd0, Q_150, -Q_HUNDRED, DIST_W'(Q_TEN));
        send_sphere(32'd0, 32'd0, -Q_THOUSAND - 2 * Q_ONE, DIST_W'(Q_ONE));
        send_sphere(32'd0, 32'd0, -Q_THOUSAND - Q_ONE / 2, DIST_W'(Q_ONE));
        send_sphere(32'd0, 32'd0, -32'sd3277, 31'd0);
        send_sphere(32'd0, 32'd0, -32'sd6554, 31'd0);
        run_phase(250, 0, 0);

        program_random_frustum(1'b1);
        run_phase(250, 54, 0);
        program_random_frustum(1'b1);
        run_phase(250, 0, 54);
        program_random_frustum(1'b0);
        run_phase(250, 37, 37);

        // Extreme distances and extreme normals
        program_frustum(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_7FFF, 32'h8000_8000,
                        32'h8000_7FFF, 32'h7FFF_8000);
        send_sphere(32'd0, 32'd0, 32'h8000_0000, 31'd0);
        send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h4000_0000);
        send_sphere(32'd0, 32'd0, 32'h8000_0001, 31'd1);
        run_phase(100, 37, 37);

        program_frustum(31'd0, 31'd1, 32'h8000_8000, 32'h8000_0001, 32'h0001_8000,
                        32'hFFFF_FFFF);
        run_phase(100, 54, 0);

        // Raw register contents
        foreach (raw[i])
            raw[i] = $urandom;
        program_frustum(raw[0][DIST_W-1:0], raw[1][DIST_W-1:0], raw[2], raw[3],
                        raw[4], raw[5]);
        run_phase(100, 0, 54);

        program_random_frustum(1'b1);
        run_phase(150, 0, 0);

        drain_pipeline();
        if (board.fail_count == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
